// ----- rtl/rrpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rrpc_pkg
// shared types and constants of the rounded rectangle containment test
// ----------------------------------------------------------------------------
package rrpc_pkg;

    // coordinate and radius widths
    localparam int COORD_WIDTH = 16;
    localparam int RADIUS_W    = 16;
    localparam int CFG_DATA_W  = 2 * RADIUS_W;
    localparam int CFG_IDX_W   = 3;

    // corner deltas: coord minus edge, minus or plus radius, never overflows
    localparam int DELTA_BASE  = (COORD_WIDTH > RADIUS_W) ? COORD_WIDTH : RADIUS_W;
    localparam int DELTA_W     = DELTA_BASE + 2;
    localparam int SQ_W        = 2 * RADIUS_W;
    localparam int PROD_W      = 2 * SQ_W;

    // pipeline shape
    localparam int NUM_STAGES  = 5;
    localparam int NUM_LANES   = 4;
    localparam int NUM_CORNERS = 4;

    // corner index, in the order the radius registers are stored
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BR = 2;
    localparam int CORNER_BL = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DELTA_W-1:0]     t_delta;
    typedef logic [RADIUS_W-1:0]           t_radius;

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_EDGE,
        REG_TOP_EDGE,
        REG_RIGHT_EDGE,
        REG_BOTTOM_EDGE,
        REG_RADIUS_TL,
        REG_RADIUS_TR,
        REG_RADIUS_BR,
        REG_RADIUS_BL
    } t_cfg_reg;

    // shape held in configuration
    typedef struct packed {
        t_coord                                left_edge;
        t_coord                                top_edge;
        t_coord                                right_edge;
        t_coord                                bottom_edge;
        logic [NUM_CORNERS-1:0][CFG_DATA_W-1:0] radius;
    } t_shape;

    // query command
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_RECT  = 1'b1;

endpackage

// ----- rtl/rrpc_in_if.sv -----
// ----------------------------------------------------------------------------
// rrpc_in_if
// query channel: command, point and far corner with valid/ready
// ----------------------------------------------------------------------------
interface rrpc_in_if;
    import rrpc_pkg::*;

    logic   valid;
    logic   ready;
    logic   command;
    t_coord point_x;
    t_coord point_y;
    t_coord far_x;
    t_coord far_y;

    modport source (
        output valid, command, point_x, point_y, far_x, far_y,
        input  ready
    );

    modport sink (
        input  valid, command, point_x, point_y, far_x, far_y,
        output ready
    );
endinterface

// ----- rtl/rrpc_out_if.sv -----
// ----------------------------------------------------------------------------
// rrpc_out_if
// result channel: containment flag with valid/ready
// ----------------------------------------------------------------------------
interface rrpc_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );

    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// ----- rtl/rrpc_lane.sv -----
// ----------------------------------------------------------------------------
// rrpc_lane
// five stage point test against the rounded rectangle: box and corner
// deltas, corner pick, squares, products, ellipse compare
// ----------------------------------------------------------------------------
module rrpc_lane (
    input  logic                             i_clk,
    input  logic [rrpc_pkg::NUM_STAGES-1:0]  i_ld,
    input  rrpc_pkg::t_shape                 i_shape,
    input  rrpc_pkg::t_coord                 i_x,
    input  rrpc_pkg::t_coord                 i_y,
    output logic                             o_inside
);
    import rrpc_pkg::*;

    // stage 1: bounding box and per corner deltas
    logic   r1_inbox;
    t_delta r1_dx [NUM_CORNERS];
    t_delta r1_dy [NUM_CORNERS];

    // stage 2: selected corner, magnitudes
    logic    r2_ok;
    logic    r2_corner;
    t_radius r2_ax;
    t_radius r2_ay;
    t_radius r2_rx;
    t_radius r2_ry;

    // stage 3: squares
    logic            r3_ok;
    logic            r3_corner;
    logic [SQ_W-1:0] r3_ax2;
    logic [SQ_W-1:0] r3_ay2;
    logic [SQ_W-1:0] r3_rx2;
    logic [SQ_W-1:0] r3_ry2;
    logic [SQ_W-1:0] r3_rxry;

    // stage 4: products
    logic              r4_ok;
    logic              r4_corner;
    logic [PROD_W-1:0] r4_a;
    logic [PROD_W-1:0] r4_b;
    logic [PROD_W-1:0] r4_lim;

    // stage 5
    logic r5_inside;

    t_delta  n1_dx [NUM_CORNERS];
    t_delta  n1_dy [NUM_CORNERS];
    logic    n1_inbox;

    logic [NUM_CORNERS-1:0] hit;
    logic    n2_corner;
    t_delta  sel_dx;
    t_delta  sel_dy;
    t_radius sel_rx;
    t_radius sel_ry;
    logic [DELTA_W-1:0] mag_x;
    logic [DELTA_W-1:0] mag_y;
    logic    n2_ok;

    logic [PROD_W:0] sum_ab;

    function automatic t_radius rad_x(input t_shape s, input int c);
        return s.radius[c][RADIUS_W-1:0];
    endfunction

    function automatic t_radius rad_y(input t_shape s, input int c);
        return s.radius[c][CFG_DATA_W-1:RADIUS_W];
    endfunction

    function automatic t_delta ext_r(input t_radius r);
        return $signed(DELTA_W'(r));
    endfunction

    function automatic logic [DELTA_W-1:0] mag(input t_delta d);
        return d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
    endfunction

    // ---------------- stage 1 ----------------
    always_comb begin
        t_delta xe, ye, le, te, re, be;
        xe = DELTA_W'(i_x);
        ye = DELTA_W'(i_y);
        le = DELTA_W'(i_shape.left_edge);
        te = DELTA_W'(i_shape.top_edge);
        re = DELTA_W'(i_shape.right_edge);
        be = DELTA_W'(i_shape.bottom_edge);
        n1_inbox = (i_x >= i_shape.left_edge) && (i_x < i_shape.right_edge)
                && (i_y >= i_shape.top_edge) && (i_y < i_shape.bottom_edge);
        n1_dx[CORNER_TL] = xe - le - ext_r(rad_x(i_shape, CORNER_TL));
        n1_dx[CORNER_BL] = xe - le - ext_r(rad_x(i_shape, CORNER_BL));
        n1_dx[CORNER_TR] = xe - re + ext_r(rad_x(i_shape, CORNER_TR));
        n1_dx[CORNER_BR] = xe - re + ext_r(rad_x(i_shape, CORNER_BR));
        n1_dy[CORNER_TL] = ye - te - ext_r(rad_y(i_shape, CORNER_TL));
        n1_dy[CORNER_TR] = ye - te - ext_r(rad_y(i_shape, CORNER_TR));
        n1_dy[CORNER_BL] = ye - be + ext_r(rad_y(i_shape, CORNER_BL));
        n1_dy[CORNER_BR] = ye - be + ext_r(rad_y(i_shape, CORNER_BR));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r1_inbox <= n1_inbox;
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r1_dx[c] <= n1_dx[c];
                r1_dy[c] <= n1_dy[c];
            end
        end
    end

    // ---------------- stage 2 ----------------
    // corner regions are tried top-left, bottom-left, top-right, bottom-right
    always_comb begin
        hit[CORNER_TL] = r1_dx[CORNER_TL][DELTA_W-1] && r1_dy[CORNER_TL][DELTA_W-1];
        hit[CORNER_BL] = r1_dx[CORNER_BL][DELTA_W-1] && (r1_dy[CORNER_BL] > 0);
        hit[CORNER_TR] = (r1_dx[CORNER_TR] > 0) && r1_dy[CORNER_TR][DELTA_W-1];
        hit[CORNER_BR] = (r1_dx[CORNER_BR] > 0) && (r1_dy[CORNER_BR] > 0);

        n2_corner = |hit;
        priority if (hit[CORNER_TL]) begin
            sel_dx = r1_dx[CORNER_TL];
            sel_dy = r1_dy[CORNER_TL];
            sel_rx = rad_x(i_shape, CORNER_TL);
            sel_ry = rad_y(i_shape, CORNER_TL);
        end else if (hit[CORNER_BL]) begin
            sel_dx = r1_dx[CORNER_BL];
            sel_dy = r1_dy[CORNER_BL];
            sel_rx = rad_x(i_shape, CORNER_BL);
            sel_ry = rad_y(i_shape, CORNER_BL);
        end else if (hit[CORNER_TR]) begin
            sel_dx = r1_dx[CORNER_TR];
            sel_dy = r1_dy[CORNER_TR];
            sel_rx = rad_x(i_shape, CORNER_TR);
            sel_ry = rad_y(i_shape, CORNER_TR);
        end else begin
            sel_dx = r1_dx[CORNER_BR];
            sel_dy = r1_dy[CORNER_BR];
            sel_rx = rad_x(i_shape, CORNER_BR);
            sel_ry = rad_y(i_shape, CORNER_BR);
        end

        mag_x = mag(sel_dx);
        mag_y = mag(sel_dy);
        // outside the radius box of the corner fails outright
        n2_ok = r1_inbox && (!n2_corner
              || ((mag_x <= DELTA_W'(sel_rx)) && (mag_y <= DELTA_W'(sel_ry))));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r2_ok     <= n2_ok;
            r2_corner <= n2_corner;
            r2_ax     <= mag_x[RADIUS_W-1:0];
            r2_ay     <= mag_y[RADIUS_W-1:0];
            r2_rx     <= sel_rx;
            r2_ry     <= sel_ry;
        end
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r3_ok     <= r2_ok;
            r3_corner <= r2_corner;
            r3_ax2    <= {{RADIUS_W{1'b0}}, r2_ax} * {{RADIUS_W{1'b0}}, r2_ax};
            r3_ay2    <= {{RADIUS_W{1'b0}}, r2_ay} * {{RADIUS_W{1'b0}}, r2_ay};
            r3_rx2    <= {{RADIUS_W{1'b0}}, r2_rx} * {{RADIUS_W{1'b0}}, r2_rx};
            r3_ry2    <= {{RADIUS_W{1'b0}}, r2_ry} * {{RADIUS_W{1'b0}}, r2_ry};
            r3_rxry   <= {{RADIUS_W{1'b0}}, r2_rx} * {{RADIUS_W{1'b0}}, r2_ry};
        end
    end

    // ---------------- stage 4 ----------------
    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r4_ok     <= r3_ok;
            r4_corner <= r3_corner;
            r4_a      <= {{SQ_W{1'b0}}, r3_ax2} * {{SQ_W{1'b0}}, r3_ry2};
            r4_b      <= {{SQ_W{1'b0}}, r3_ay2} * {{SQ_W{1'b0}}, r3_rx2};
            r4_lim    <= {{SQ_W{1'b0}}, r3_rxry} * {{SQ_W{1'b0}}, r3_rxry};
        end
    end

    // ---------------- stage 5 ----------------
    // dx^2 ry^2 + dy^2 rx^2 <= (rx ry)^2, exact in one extra bit
    assign sum_ab = {1'b0, r4_a} + {1'b0, r4_b};

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r5_inside <= r4_ok && (!r4_corner || (sum_ab <= {1'b0, r4_lim}));
        end
    end

    assign o_inside = r5_inside;

endmodule

// ----- rtl/rounded_rect_point_containment_top.sv -----
// ----------------------------------------------------------------------------
// rounded_rect_point_containment_top
// clip-shape hit test of points and rectangles against one rounded rectangle
// ----------------------------------------------------------------------------
// Accepts one query transaction every clock cycle unless backpressure holds
// the pipe, and returns one result transaction per query, in order. A query
// passes through five pipeline stages (box and corner deltas, corner pick
// and magnitude check, 16x16 squares, 32x32 products, ellipse compare) and
// then the output register; the two multiplier ranks set the depth. Four
// identical lanes test the four corners of a rectangle query side by side,
// a point query uses lane 0 only. Backpressure stalls only the stages that
// hold data, so bubbles collapse and nothing is lost or repeated. The shape
// registers (edges signed Q12.4, radii packed y:x unsigned Q12.4) are read
// live by the pipeline: write them only while no query is in flight.
// ----------------------------------------------------------------------------
module rounded_rect_point_containment_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rrpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rrpc_in_if.sink                           i_req,
    rrpc_out_if.source                        o_rsp
);
    import rrpc_pkg::*;

    // shape registers
    t_shape r_shape;

    // pipeline control: valid bit and command per stage
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] r_cmd;
    logic                  r_vo;
    logic                  r_res;

    // stage load enables, computed from the back of the pipe
    logic [NUM_STAGES-1:0] ld;
    logic                  ld_out;

    // lane operands and results
    t_coord                lane_x [NUM_LANES];
    t_coord                lane_y [NUM_LANES];
    logic [NUM_LANES-1:0]  lane_in;

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_LEFT_EDGE:   r_shape.left_edge   <= i_cfg_data[COORD_WIDTH-1:0];
                REG_TOP_EDGE:    r_shape.top_edge    <= i_cfg_data[COORD_WIDTH-1:0];
                REG_RIGHT_EDGE:  r_shape.right_edge  <= i_cfg_data[COORD_WIDTH-1:0];
                REG_BOTTOM_EDGE: r_shape.bottom_edge <= i_cfg_data[COORD_WIDTH-1:0];
                REG_RADIUS_TL:   r_shape.radius[CORNER_TL] <= i_cfg_data;
                REG_RADIUS_TR:   r_shape.radius[CORNER_TR] <= i_cfg_data;
                REG_RADIUS_BR:   r_shape.radius[CORNER_BR] <= i_cfg_data;
                REG_RADIUS_BL:   r_shape.radius[CORNER_BL] <= i_cfg_data;
                default:         r_shape <= r_shape;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // a stage loads when it is empty or the stage after it loads too
    always_comb begin
        ld_out             = !r_vo || o_rsp.ready;
        ld[NUM_STAGES-1]   = !r_v[NUM_STAGES-1] || ld_out;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign i_req.ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (ld_out) begin
                r_vo <= r_v[NUM_STAGES-1];
            end
        end
    end

    // command rides along with the valid bits
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_cmd[0] <= i_req.command;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ld[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    // ---------------- lanes ----------------
    // lane 0: point or top-left, 1: top-right, 2: bottom-right, 3: bottom-left
    always_comb begin
        lane_x[0] = i_req.point_x;
        lane_y[0] = i_req.point_y;
        lane_x[1] = i_req.far_x;
        lane_y[1] = i_req.point_y;
        lane_x[2] = i_req.far_x;
        lane_y[2] = i_req.far_y;
        lane_x[3] = i_req.point_x;
        lane_y[3] = i_req.far_y;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rrpc_lane u_lane (
            .i_clk    (i_clk),
            .i_ld     (ld),
            .i_shape  (r_shape),
            .i_x      (lane_x[g]),
            .i_y      (lane_y[g]),
            .o_inside (lane_in[g])
        );
    end

    // ---------------- output register ----------------
    // rectangle is inside only when all four corners are
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_res <= (r_cmd[NUM_STAGES-1] == CMD_RECT) ? (&lane_in) : lane_in[0];
        end
    end

    assign o_rsp.valid      = r_vo;
    assign o_rsp.inside_res = r_res;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rounded rectangle containment test
// ----------------------------------------------------------------------------
// Loads a series of rounded rectangles through the register port and fires
// point and rectangle queries at each one. A predictor in the bench works out
// the containment flag of every accepted query, and the flags are checked in
// order against the result channel. Both channels idle at random. A pressure
// test holds the result side off long enough to stall the query side.
// ----------------------------------------------------------------------------
module tb;
    import rrpc_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int IDLE_PCT        = 7;
    localparam int MISMATCH_PRINTS = 10;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_QUERIES   = 130;
    localparam int STREAM_QUERIES  = 150;
    localparam int STALL_QUERIES   = 150;
    localparam int STALL_CYCLES    = 300;

    // one query transaction as the bench sees it
    typedef struct {
        logic   command;
        t_coord point_x;
        t_coord point_y;
        t_coord far_x;
        t_coord far_y;
    } t_query;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rrpc_in_if  req_if ();
    rrpc_out_if rsp_if ();

    rounded_rect_point_containment_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // shadow copy of the shape registers, indexed like the register map
    t_coord                shape_edge [4]             = '{default: '0};
    logic [CFG_DATA_W-1:0] corner_radius [NUM_CORNERS] = '{default: '0};

    // containment flags still owed by the block, oldest first
    bit inside_due_q [$];
    int fail_count      = 0;
    int cycle_count     = 0;
    bit idle_enabled    = 1'b1;
    int rsp_hold_cycles = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic longint radius_x(int corner);
        return longint'(corner_radius[corner][RADIUS_W-1:0]);
    endfunction

    function automatic longint radius_y(int corner);
        return longint'(corner_radius[corner][CFG_DATA_W-1:RADIUS_W]);
    endfunction

    // exact ellipse test: dx^2*ry^2 + dy^2*rx^2 <= (rx*ry)^2, 128 bits is plenty
    function automatic bit corner_ellipse_holds(longint dx, longint dy,
                                                longint rx, longint ry);
        logic [127:0] ax, ay, wx, wy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        wx = rx;
        wy = ry;
        if (ax > wx || ay > wy)
            return 1'b0;
        return (ax * ax * wy * wy + ay * ay * wx * wx) <= (wx * wy * wx * wy);
    endfunction

    function automatic bit shape_covers_point(longint x, longint y);
        longint lft, top, rgt, bot, rx, ry;
        lft = shape_edge[REG_LEFT_EDGE];
        top = shape_edge[REG_TOP_EDGE];
        rgt = shape_edge[REG_RIGHT_EDGE];
        bot = shape_edge[REG_BOTTOM_EDGE];
        // half-open box, an empty or inverted box holds nothing
        if (!(x >= lft && x < rgt && y >= top && y < bot))
            return 1'b0;
        // corner regions in priority order: tl, bl, tr, br; first hit decides
        rx = radius_x(CORNER_TL);
        ry = radius_y(CORNER_TL);
        if (x < lft + rx && y < top + ry)
            return corner_ellipse_holds(x - (lft + rx), y - (top + ry), rx, ry);
        rx = radius_x(CORNER_BL);
        ry = radius_y(CORNER_BL);
        if (x < lft + rx && y > bot - ry)
            return corner_ellipse_holds(x - (lft + rx), y - (bot - ry), rx, ry);
        rx = radius_x(CORNER_TR);
        ry = radius_y(CORNER_TR);
        if (x > rgt - rx && y < top + ry)
            return corner_ellipse_holds(x - (rgt - rx), y - (top + ry), rx, ry);
        rx = radius_x(CORNER_BR);
        ry = radius_y(CORNER_BR);
        if (x > rgt - rx && y > bot - ry)
            return corner_ellipse_holds(x - (rgt - rx), y - (bot - ry), rx, ry);
        return 1'b1;
    endfunction

    function automatic bit shape_covers_query(t_query q);
        if (q.command == CMD_POINT)
            return shape_covers_point(q.point_x, q.point_y);
        // rectangle: all four corners as given, inverted or not
        return shape_covers_point(q.point_x, q.point_y) &&
               shape_covers_point(q.far_x, q.point_y) &&
               shape_covers_point(q.far_x, q.far_y) &&
               shape_covers_point(q.point_x, q.far_y);
    endfunction

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------

    // leaves the write enable high, load_shape lowers it after the last write
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_LEFT_EDGE, REG_TOP_EDGE, REG_RIGHT_EDGE, REG_BOTTOM_EDGE: begin
                shape_edge[idx] = data[COORD_WIDTH-1:0];
            end
            default: begin
                corner_radius[idx - REG_RADIUS_TL] = data;
            end
        endcase
        @(posedge i_clk);
    endtask

    // writes all eight registers; junk above the edge bits must be dropped
    task automatic load_shape(int lft, int top, int rgt, int bot,
                              logic [CFG_DATA_W-1:0] r_tl, logic [CFG_DATA_W-1:0] r_tr,
                              logic [CFG_DATA_W-1:0] r_br, logic [CFG_DATA_W-1:0] r_bl);
        write_reg(REG_LEFT_EDGE,   {16'($urandom), 16'(lft)});
        write_reg(REG_TOP_EDGE,    {16'($urandom), 16'(top)});
        write_reg(REG_RIGHT_EDGE,  {16'($urandom), 16'(rgt)});
        write_reg(REG_BOTTOM_EDGE, {16'($urandom), 16'(bot)});
        write_reg(REG_RADIUS_TL,   r_tl);
        write_reg(REG_RADIUS_TR,   r_tr);
        write_reg(REG_RADIUS_BR,   r_br);
        write_reg(REG_RADIUS_BL,   r_bl);
        i_cfg_we <= 1'b0;
    endtask

    // mostly radii that fit the box, some zero, some oversized, some raw
    function automatic logic [CFG_DATA_W-1:0] random_radius(int w, int h);
        int rx, ry;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2: begin
                rx = $urandom_range(0, 2 * w);
                ry = $urandom_range(0, 2 * h);
            end
            default: begin
                rx = $urandom_range(0, w / 2);
                ry = $urandom_range(0, h / 2);
            end
        endcase
        return {16'(ry), 16'(rx)};
    endfunction

    task automatic load_random_shape();
        int kind, lft, top, w, h;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // anything goes, often inverted or huge
            load_shape($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        end else if (kind == 1) begin
            // empty or inverted box
            lft = int'($urandom_range(0, 2000)) - 1000;
            top = int'($urandom_range(0, 2000)) - 1000;
            load_shape(lft, top, lft - int'($urandom_range(0, 200)),
                       top + int'($urandom_range(0, 200)),
                       random_radius(100, 100), random_radius(100, 100),
                       random_radius(100, 100), random_radius(100, 100));
        end else begin
            w   = (kind == 2) ? $urandom_range(1, 8) : $urandom_range(1, 3000);
            h   = (kind == 2) ? $urandom_range(1, 8) : $urandom_range(1, 3000);
            lft = int'($urandom_range(0, 40000)) - 20000;
            top = int'($urandom_range(0, 40000)) - 20000;
            load_shape(lft, top, lft + w, top + h,
                       random_radius(w, h), random_radius(w, h),
                       random_radius(w, h), random_radius(w, h));
        end
    endtask

    // ------------------------------------------------------------------------
    // query side
    // ------------------------------------------------------------------------

    // random gaps, then holds the transaction until the block takes it
    task automatic send_query(t_query q);
        while (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= q.command;
        req_if.point_x <= q.point_x;
        req_if.point_y <= q.point_y;
        req_if.far_x   <= q.far_x;
        req_if.far_y   <= q.far_y;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        inside_due_q.push_back(shape_covers_query(q));
    endtask

    // far corner carries junk on a point query, it must be ignored
    task automatic send_point(int x, int y);
        t_query q;
        q = '{CMD_POINT, t_coord'(x), t_coord'(y), t_coord'($urandom), t_coord'($urandom)};
        send_query(q);
    endtask

    task automatic send_rect(int x0, int y0, int x1, int y1);
        t_query q;
        q = '{CMD_RECT, t_coord'(x0), t_coord'(y0), t_coord'(x1), t_coord'(y1)};
        send_query(q);
    endtask

    // stop offering and wait until every owed flag has come back
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (inside_due_q.size() != 0);
    endtask

    // coordinates near the box edges, inside the span, or anywhere at all
    function automatic t_coord coord_near(t_coord lo, t_coord hi);
        longint span, jitter, pick;
        span   = longint'(hi) - longint'(lo);
        jitter = longint'($urandom_range(0, 128)) - 64;
        case ($urandom_range(0, 9))
            0:       pick = $urandom_range(0, 65535);
            1, 2:    pick = longint'(lo) + jitter;
            3, 4:    pick = longint'(hi) + jitter;
            default: pick = (span > 0) ? longint'(lo) + longint'($urandom_range(0, span))
                                       : longint'(lo) + jitter;
        endcase
        return t_coord'(pick);
    endfunction

    function automatic t_query random_query();
        t_query q;
        q.command = $urandom_range(0, 1) ? CMD_RECT : CMD_POINT;
        q.point_x = coord_near(shape_edge[REG_LEFT_EDGE], shape_edge[REG_RIGHT_EDGE]);
        q.point_y = coord_near(shape_edge[REG_TOP_EDGE], shape_edge[REG_BOTTOM_EDGE]);
        q.far_x   = coord_near(shape_edge[REG_LEFT_EDGE], shape_edge[REG_RIGHT_EDGE]);
        q.far_y   = coord_near(shape_edge[REG_TOP_EDGE], shape_edge[REG_BOTTOM_EDGE]);
        return q;
    endfunction

    task automatic send_random_queries(int count);
        for (int n = 0; n < count; n++)
            send_query(random_query());
    endtask

    // ------------------------------------------------------------------------
    // result side: checks each transaction, then picks next cycle's ready
    // ------------------------------------------------------------------------
    initial begin
        bit inside_due;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                if (inside_due_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MISMATCH_PRINTS)
                        $display("unexpected result transaction: inside_res=%b",
                                 rsp_if.inside_res);
                end else begin
                    inside_due = inside_due_q.pop_front();
                    if (rsp_if.inside_res !== inside_due) begin
                        fail_count++;
                        if (fail_count <= MISMATCH_PRINTS)
                            $display("inside_res mismatch: expected %b, actual %b",
                                     inside_due, rsp_if.inside_res);
                    end
                end
            end
            // a long hold-off counts down here, independent of the query side
            if (rsp_hold_cycles > 0) begin
                rsp_hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers reset to zero: a zero-size box holds nothing
    task automatic test_reset_shape();
        send_point(0, 0);
        wait_drain();
    endtask

    // arcs, edge boundaries, a zero-height corner, field extremes, rectangles
    task automatic test_corner_arcs();
        load_shape(-800, -480, 960, 640,
                   {16'd96, 16'd160}, {16'd0, 16'd200},
                   {16'd320, 16'd320}, {16'd256, 16'd64});
        send_point(-800, -480);    // box corner, outside the arc
        send_point(-640, -480);    // arc touches the top edge
        send_point(-800, -384);    // arc touches the left edge
        send_point(-760, -460);
        send_point(960, 0);        // right edge is open
        send_point(959, 0);
        send_point(0, 640);        // bottom edge is open
        send_point(0, 639);
        send_point(959, -480);     // zero y radius: no corner region
        send_point(-32768, -32768);
        send_point(32767, 32767);
        send_rect(-100, -100, 100, 100);
        send_rect(100, 100, -100, -100);   // inverted query rectangle
        send_rect(-800, -480, 0, 0);
        wait_drain();
    endtask

    // oversized radii overlap: top-left region wins over bottom-left
    task automatic test_corner_priority();
        load_shape(0, 0, 320, 320, {16'd200, 16'd320}, '0, '0, {16'd200, 16'd320});
        send_point(10, 150);
        send_point(10, 170);
        send_point(160, 160);
        send_point(300, 310);
        wait_drain();
    endtask

    // widest box, largest radii: the products run at full width
    task automatic test_extreme_shape();
        load_shape(-32768, -32768, 32767, 32767, '1, '1, '1, '1);
        send_point(-32768, -32768);
        send_point(-1, -1);
        send_point(32766, 32766);
        send_rect(-32768, -32768, 32766, 32766);
        wait_drain();
    endtask

    // left edge right of the right edge
    task automatic test_inverted_box();
        load_shape(100, 0, -100, 100, '0, '0, '0, '0);
        send_point(0, 50);
        wait_drain();
    endtask

    task automatic test_random_shapes();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_random_shape();
            send_random_queries(PHASE_QUERIES);
            wait_drain();
        end
    endtask

    // back to back on both sides, no idling at all
    task automatic test_steady_stream();
        idle_enabled = 1'b0;
        load_random_shape();
        send_random_queries(STREAM_QUERIES);
        wait_drain();
        idle_enabled = 1'b1;
    endtask

    // result side holds off until the pipe is full and the query side stalls,
    // then the query side waits for everything before carrying on
    task automatic test_backpressure();
        idle_enabled = 1'b0;
        load_random_shape();
        rsp_hold_cycles = STALL_CYCLES;
        send_random_queries(STALL_QUERIES);
        wait_drain();
        send_random_queries(STALL_QUERIES / 3);
        wait_drain();
        idle_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_LEFT_EDGE;
        i_cfg_data     <= '0;
        req_if.valid   <= 1'b0;
        req_if.command <= CMD_POINT;
        req_if.point_x <= '0;
        req_if.point_y <= '0;
        req_if.far_x   <= '0;
        req_if.far_y   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_shape();
        test_corner_arcs();
        test_corner_priority();
        test_extreme_shape();
        test_inverted_box();
        test_random_shapes();
        test_steady_stream();
        test_backpressure();

        // anything arriving now is a stray transaction
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rrpc_pkg.sv
rtl/rrpc_in_if.sv
rtl/rrpc_out_if.sv
rtl/rrpc_lane.sv
rtl/rounded_rect_point_containment_top.sv
tb/tb.sv
